### sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Short forms for concurrent assertions clocked by clk and disabled by rst.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/urm_pkg.sv
// ============================================================================
// urm_pkg
// Types, constants and helper functions shared by the UART register model.
// ============================================================================
package urm_pkg;

  // Receive FIFO geometry.
  localparam int RX_DEPTH = 64;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  // Depth of the command queue and the result queue.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SHIFT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_WIDTH = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ADDR_SHIFT_RESET   = 3'd0;
  localparam logic [CFG_DATA_W-1:0] ACCESS_WIDTH_RESET = 3'd1;

  // Item function codes.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_HOST  = 2'd2;

  // Register selects after shifting and masking the bus offset.
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  // Register reset values and fixed codes.
  localparam logic [7:0] DLL_RESET    = 8'h0C;
  localparam logic [7:0] MCR_RESET    = 8'h08;
  localparam logic [7:0] LSR_RESET    = 8'h60;
  localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
  localparam logic [7:0] IIR_TYPE     = 8'hC0;
  localparam logic [7:0] MSR_CONST    = 8'hB0;
  localparam logic [3:0] IER_MASK     = 4'hF;
  localparam logic [3:0] IIR_NONE     = 4'h1;
  localparam logic [3:0] IIR_RDI      = 4'h4;
  localparam logic [3:0] IIR_THRI     = 4'h2;

  // Bit positions.
  localparam int LCR_DLAB_BIT   = 7;
  localparam int MCR_LOOP_BIT   = 4;
  localparam int LSR_DR_BIT     = 0;
  localparam int LSR_TEMT_BIT   = 6;
  localparam int IER_RDI_BIT    = 0;
  localparam int IER_THRI_BIT   = 1;
  localparam int FCR_CLR_RX_BIT = 1;
  localparam int FCR_CLR_TX_BIT = 2;

  // Classified operation handed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_REJECT,
    OP_READ,
    OP_WRITE,
    OP_HOST
  } op_t;

  // One input item.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] addr;
    logic [2:0] access_width;
    logic [7:0] wdata;
    logic [7:0] host_byte;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic       rx_room;
  } rsp_t;

  // Decoded command in the queue between front and back.
  typedef struct packed {
    op_t        op;
    logic [2:0] sel;
    logic [7:0] data;
  } cmd_t;

  // Advance a queue pointer with wrap.
  function automatic logic [Q_PTR_W-1:0] q_ptr_next(input logic [Q_PTR_W-1:0] ptr);
    return (ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Advance a receive FIFO pointer with wrap.
  function automatic logic [RX_PTR_W-1:0] rx_ptr_next(input logic [RX_PTR_W-1:0] ptr);
    return (ptr == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

### sv/urm_ram.sv
// ============================================================================
// urm_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module urm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read that returns the contents before this edge's write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/urm_front.sv
// ============================================================================
// urm_front
// Holds the configuration, classifies each incoming item and queues the
// decoded command for the back part.
// ============================================================================
module urm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [urm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  input  urm_pkg::req_t                  request,
  output logic                           full,
  output logic                           cmd_valid,
  output urm_pkg::cmd_t                  cmd,
  input  logic                           cmd_take
);
  import urm_pkg::*;

  logic [CFG_DATA_W-1:0] addr_shift;
  logic [CFG_DATA_W-1:0] access_width_cfg;
  logic [7:0]            shifted_addr;
  cmd_t                  dec;
  cmd_t                  q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr;
  logic [Q_PTR_W-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0]    q_count;
  logic                  do_push;
  logic                  do_pop;

  // Configuration registers; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_shift       <= ADDR_SHIFT_RESET;
      access_width_cfg <= ACCESS_WIDTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ADDR_SHIFT) begin
        addr_shift <= cfg_data;
      end
      if (cfg_index == CFG_ACCESS_WIDTH) begin
        access_width_cfg <= cfg_data;
      end
    end
  end

  // Classify the item: register select, width check and payload byte.
  always_comb begin
    shifted_addr = request.addr >> addr_shift;
    dec.sel      = shifted_addr[2:0];
    dec.data     = (request.func == FUNC_HOST) ? request.host_byte : request.wdata;
    unique case (request.func)
      FUNC_READ: begin
        dec.op = (request.access_width == access_width_cfg) ? OP_READ : OP_REJECT;
      end
      FUNC_WRITE: begin
        dec.op = (request.access_width == access_width_cfg) ? OP_WRITE : OP_REJECT;
      end
      FUNC_HOST: begin
        dec.op = OP_HOST;
      end
      default: begin
        dec.op = OP_NOP;
      end
    endcase
  end

  // Command queue between the front and the back part.
  assign full      = (q_count == Q_CNT_W'(Q_DEPTH));
  assign cmd_valid = (q_count != '0);
  assign cmd       = q_mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= q_ptr_next(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= q_ptr_next(rd_ptr);
      end
      if (do_push && !do_pop) begin
        q_count <= q_count + 1'b1;
      end else if (do_pop && !do_push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

### sv/urm_result_q.sv
// ============================================================================
// urm_result_q
// Short queue of finished result items in front of the result port.
// ============================================================================
module urm_result_q (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  urm_pkg::rsp_t wr_data,
  output logic          wr_full,
  output logic          empty,
  input  logic          pop,
  output urm_pkg::rsp_t rd_data
);
  import urm_pkg::*;

  rsp_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] q_count;
  logic               do_push;
  logic               do_pop;

  // Status and the oldest waiting item.
  assign wr_full = (q_count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (q_count == '0);
  assign rd_data = q_mem[rd_ptr];
  assign do_push = wr && !wr_full;
  assign do_pop  = pop && !empty;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= q_ptr_next(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= q_ptr_next(rd_ptr);
      end
      if (do_push && !do_pop) begin
        q_count <= q_count + 1'b1;
      end else if (do_pop && !do_push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

### sv/urm_back.sv
// ============================================================================
// urm_back
// Executes decoded commands against the UART registers and the receive FIFO,
// one command per cycle while the result queue has room, and queues each result.
// ============================================================================
`include "assert_macros.svh"

module urm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  urm_pkg::cmd_t cmd,
  output logic          cmd_take,
  input  logic          res_full,
  output logic          res_wr,
  output urm_pkg::rsp_t res
);
  import urm_pkg::*;

  // Architectural registers.
  logic [7:0]          dll;
  logic [7:0]          dlm;
  logic [3:0]          ier;
  logic [7:0]          fcr;
  logic [7:0]          lcr;
  logic [7:0]          mcr;
  logic [7:0]          lsr;
  logic [7:0]          scr;
  logic [3:0]          iir;
  logic                irq_level;
  logic [RX_PTR_W-1:0] rx_head;
  logic [RX_PTR_W-1:0] rx_tail;
  logic [RX_CNT_W-1:0] rx_count;

  // Next values.
  logic [7:0]          dll_next;
  logic [7:0]          dlm_next;
  logic [3:0]          ier_next;
  logic [7:0]          fcr_next;
  logic [7:0]          lcr_next;
  logic [7:0]          mcr_next;
  logic [7:0]          lsr_next;
  logic [7:0]          scr_next;
  logic [3:0]          iir_next;
  logic                irq_level_next;
  logic [RX_PTR_W-1:0] rx_head_next;
  logic [RX_PTR_W-1:0] rx_tail_next;
  logic [RX_CNT_W-1:0] rx_count_next;

  // Execution controls.
  logic                fire;
  logic                dlab;
  logic                loop_mode;
  logic                rx_full;
  logic                rx_push;
  logic                rx_pop;
  logic                rx_clear;
  logic                int_update;
  logic [7:0]          rx_data;
  logic [7:0]          ram_q;
  logic [RX_PTR_W-1:0] ram_raddr;
  logic                ram_we;
  logic                byp_valid;
  logic [7:0]          byp_data;

  assign fire      = cmd_valid && !res_full;
  assign cmd_take  = fire;
  assign res_wr    = fire;
  assign dlab      = lcr[LCR_DLAB_BIT];
  assign loop_mode = mcr[MCR_LOOP_BIT];
  assign rx_full   = (rx_count == RX_CNT_W'(RX_DEPTH));
  assign rx_data   = byp_valid ? byp_data : ram_q;

  // Command execution and interrupt update.
  always_comb begin
    dll_next       = dll;
    dlm_next       = dlm;
    ier_next       = ier;
    fcr_next       = fcr;
    lcr_next       = lcr;
    mcr_next       = mcr;
    lsr_next       = lsr;
    scr_next       = scr;
    iir_next       = iir;
    irq_level_next = irq_level;
    rx_push        = 1'b0;
    rx_pop         = 1'b0;
    rx_clear       = 1'b0;
    int_update     = 1'b0;
    res            = '0;

    unique case (cmd.op)
      OP_READ: begin
        unique case (cmd.sel)
          REG_DATA: begin
            int_update = 1'b1;
            if (dlab) begin
              res.read_data = dll;
            end else if (rx_count == '0) begin
              lsr_next[LSR_DR_BIT] = 1'b0;
            end else begin
              res.read_data = rx_data;
              rx_pop        = 1'b1;
              if (rx_count == RX_CNT_W'(1)) begin
                lsr_next[LSR_DR_BIT] = 1'b0;
              end
            end
          end
          REG_IER: res.read_data = dlab ? dlm : {4'b0000, ier};
          REG_IIR: res.read_data = {4'b0000, iir} | IIR_TYPE;
          REG_LCR: res.read_data = lcr;
          REG_MCR: res.read_data = mcr;
          REG_LSR: res.read_data = lsr;
          REG_MSR: res.read_data = MSR_CONST;
          REG_SCR: res.read_data = scr;
        endcase
      end
      OP_WRITE: begin
        unique case (cmd.sel)
          REG_DATA: begin
            int_update = 1'b1;
            if (dlab) begin
              dll_next = cmd.data;
            end else if (loop_mode) begin
              if (!rx_full) begin
                rx_push              = 1'b1;
                lsr_next[LSR_DR_BIT] = 1'b1;
              end
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = cmd.data;
              lsr_next     = lsr_next | LSR_TX_EMPTY;
            end
          end
          REG_IER: begin
            int_update = 1'b1;
            if (dlab) begin
              dlm_next = cmd.data;
            end else begin
              ier_next = cmd.data[3:0] & IER_MASK;
            end
          end
          REG_IIR: begin
            int_update = 1'b1;
            fcr_next   = cmd.data;
          end
          REG_LCR: begin
            int_update = 1'b1;
            lcr_next   = cmd.data;
          end
          REG_MCR: begin
            int_update = 1'b1;
            mcr_next   = cmd.data;
          end
          REG_SCR: scr_next = cmd.data;
          REG_LSR, REG_MSR: begin
          end
        endcase
      end
      OP_HOST: begin
        // A host byte is ignored in loopback and dropped when the FIFO is full.
        if (!loop_mode) begin
          rx_push              = !rx_full;
          lsr_next[LSR_DR_BIT] = 1'b1;
          int_update           = 1'b1;
        end
      end
      OP_REJECT: res.status = 1'b1;
      default: begin
      end
    endcase

    // Interrupt update: self-clearing FIFO resets, then the IIR priority.
    if (int_update) begin
      if (fcr_next[FCR_CLR_RX_BIT]) begin
        fcr_next[FCR_CLR_RX_BIT] = 1'b0;
        rx_clear                 = 1'b1;
        lsr_next[LSR_DR_BIT]     = 1'b0;
      end
      if (fcr_next[FCR_CLR_TX_BIT]) begin
        fcr_next[FCR_CLR_TX_BIT] = 1'b0;
        lsr_next                 = lsr_next | LSR_TX_EMPTY;
      end
      if (ier_next[IER_RDI_BIT] && lsr_next[LSR_DR_BIT]) begin
        iir_next = IIR_RDI;
      end else if (ier_next[IER_THRI_BIT] && lsr_next[LSR_TEMT_BIT]) begin
        iir_next = IIR_THRI;
      end else begin
        iir_next = IIR_NONE;
      end
      irq_level_next = (iir_next != IIR_NONE);
      if (!ier_next[IER_THRI_BIT]) begin
        lsr_next = lsr_next | LSR_TX_EMPTY;
      end
    end

    // Receive FIFO pointers; a clear overrides any push or pop.
    rx_head_next  = rx_head;
    rx_tail_next  = rx_tail;
    rx_count_next = rx_count;
    if (rx_clear) begin
      rx_head_next  = '0;
      rx_tail_next  = '0;
      rx_count_next = '0;
    end else if (rx_pop) begin
      rx_head_next  = rx_ptr_next(rx_head);
      rx_count_next = rx_count - 1'b1;
    end else if (rx_push) begin
      rx_tail_next  = rx_ptr_next(rx_tail);
      rx_count_next = rx_count + 1'b1;
    end

    res.irq     = irq_level_next;
    res.rx_room = !mcr_next[MCR_LOOP_BIT] && (rx_count_next != RX_CNT_W'(RX_DEPTH));
  end

  // The memory always reads the entry at the head the next command will see.
  assign ram_we    = fire && rx_push;
  assign ram_raddr = fire ? rx_head_next : rx_head;

  urm_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rx_tail),
    .wdata (cmd.data),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Forward a byte written to the entry that is being read in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= ram_we && (rx_tail == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_data <= cmd.data;
    end
  end

  // Register state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dll       <= DLL_RESET;
      dlm       <= '0;
      ier       <= '0;
      fcr       <= '0;
      lcr       <= '0;
      mcr       <= MCR_RESET;
      lsr       <= LSR_RESET;
      scr       <= '0;
      iir       <= IIR_NONE;
      irq_level <= 1'b0;
      rx_head   <= '0;
      rx_tail   <= '0;
      rx_count  <= '0;
    end else if (fire) begin
      dll       <= dll_next;
      dlm       <= dlm_next;
      ier       <= ier_next;
      fcr       <= fcr_next;
      lcr       <= lcr_next;
      mcr       <= mcr_next;
      lsr       <= lsr_next;
      scr       <= scr_next;
      iir       <= iir_next;
      irq_level <= irq_level_next;
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      rx_count  <= rx_count_next;
    end
  end

  // Checks on the register and FIFO state.
  `URM_ASSERT_NOW(a_rx_count_bound, 1'b1, rx_count <= RX_CNT_W'(RX_DEPTH), "rx count overflow")
  `URM_ASSERT_NOW(a_dr_tracks_fifo, 1'b1, lsr[LSR_DR_BIT] == (rx_count != '0), "DR out of step")
  `URM_ASSERT_NOW(a_irq_follows_iir, 1'b1, irq_level == (iir != IIR_NONE), "irq differs from IIR")
  `URM_ASSERT_NEXT(a_fcr_self_clear, fire && (cmd.op == OP_WRITE) && (cmd.sel == REG_IIR), !fcr[FCR_CLR_RX_BIT] && !fcr[FCR_CLR_TX_BIT], "FCR clear bits stuck")

endmodule

### sv/uart_16550_register_model_unit.sv
// ============================================================================
// uart_16550_register_model_unit: register side of a 16550-style UART
// An accepted item waits in the command queue until the back part executes it;
// its result then waits in the result queue, whose oldest entry is on the result ports.
// Throughput: one item per cycle from the execute stage, while the result queue has room.
// Reset (rst, synchronous): registers take their reset values and both queues empty.
// ============================================================================
module uart_16550_register_model_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  urm_pkg::req_t                  request,
  output logic                           empty,
  input  logic                           pop,
  output urm_pkg::rsp_t                  result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [urm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import urm_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_full;
  logic res_wr;
  rsp_t res;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Accept, classify and queue items.
  urm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .request   (request),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Execute commands against the registers and the receive FIFO.
  urm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res)
  );

  // Hold finished items until they are popped.
  urm_result_q u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_wr),
    .wr_data (res),
    .wr_full (res_full),
    .empty   (empty),
    .pop     (pop),
    .rd_data (result)
  );

endmodule
